/* hw/rtl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg
// shared widths, transaction types and helper functions for the
// quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 29;
   localparam int PROD_W       = 32;
   localparam int TERM_W       = 34;
   localparam int VEC_W        = 37;
   localparam int ANG_W        = 28;
   localparam int REM_W        = 57;
   localparam int RAD_W        = 58;
   localparam int STEP_W       = 5;
   localparam int SQ_W         = 5;
   localparam int OUT_W        = 16;
   localparam int PITCH_W      = 15;

   localparam logic signed [TERM_W-1:0] ONE_Q28     = TERM_W'(268435456);
   localparam logic signed [ANG_W-1:0]  HALF_PI_Q24 = ANG_W'(26353589);
   localparam logic signed [OUT_W-1:0]  PI_Q13      = OUT_W'(25736);
   localparam logic signed [OUT_W-1:0]  HALF_PI_Q13 = OUT_W'(12868);

   typedef struct packed {
      logic                     valid;
      logic                     clamp;
      logic                     sp_pos;
      logic [REM_W-1:0]         rem;
      logic [RAD_W-1:0]         res;
      logic signed [TERM_W-1:0] sr;
      logic signed [TERM_W-1:0] cr;
      logic signed [TERM_W-1:0] sp;
      logic signed [TERM_W-1:0] sy;
      logic signed [TERM_W-1:0] cy;
   } sq_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } lane_type;

   typedef struct packed {
      logic     valid;
      logic     clamp;
      logic     sp_pos;
      lane_type roll;
      lane_type pitch;
      lane_type yaw;
   } cd_type;

   function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [ANG_W-1:0] v;
      unique case (idx)
         5'd0:    v = ANG_W'(13176795);
         5'd1:    v = ANG_W'(7778716);
         5'd2:    v = ANG_W'(4110060);
         5'd3:    v = ANG_W'(2086331);
         5'd4:    v = ANG_W'(1047214);
         5'd5:    v = ANG_W'(524117);
         5'd6:    v = ANG_W'(262123);
         5'd7:    v = ANG_W'(131069);
         5'd8:    v = ANG_W'(65536);
         5'd9:    v = ANG_W'(32768);
         5'd10:   v = ANG_W'(16384);
         5'd11:   v = ANG_W'(8192);
         5'd12:   v = ANG_W'(4096);
         5'd13:   v = ANG_W'(2048);
         5'd14:   v = ANG_W'(1024);
         5'd15:   v = ANG_W'(512);
         5'd16:   v = ANG_W'(256);
         5'd17:   v = ANG_W'(128);
         5'd18:   v = ANG_W'(64);
         5'd19:   v = ANG_W'(32);
         5'd20:   v = ANG_W'(16);
         5'd21:   v = ANG_W'(8);
         5'd22:   v = ANG_W'(4);
         5'd23:   v = ANG_W'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

   // quadrant fold so the vector starts in the right half plane
   function automatic lane_type prerot(input logic signed [TERM_W-1:0] y_in,
                                       input logic signed [TERM_W-1:0] x_in);
      lane_type                l;
      logic signed [VEC_W-1:0] xe;
      logic signed [VEC_W-1:0] ye;
      xe = {{(VEC_W-TERM_W){x_in[TERM_W-1]}}, x_in};
      ye = {{(VEC_W-TERM_W){y_in[TERM_W-1]}}, y_in};
      l.zero = (x_in == '0) && (y_in == '0);
      if (x_in[TERM_W-1]) begin
         if (!y_in[TERM_W-1]) begin
            l.x = ye;
            l.y = -xe;
            l.z = HALF_PI_Q24;
         end else begin
            l.x = -ye;
            l.y = xe;
            l.z = -HALF_PI_Q24;
         end
      end else begin
         l.x = xe;
         l.y = ye;
         l.z = '0;
      end
      return l;
   endfunction

   // q24 to q13, half away from zero, then saturate
   function automatic logic signed [OUT_W-1:0] round_angle(
      input logic signed [ANG_W-1:0] a,
      input logic signed [OUT_W-1:0] lim);
      logic [ANG_W-1:0]         mag;
      logic [ANG_W-1:0]         sum;
      logic [ANG_W-12:0]        r;
      logic signed [ANG_W-10:0] sv;
      logic signed [ANG_W-10:0] le;
      mag = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
      sum = mag + ANG_W'(1024);
      r   = sum[ANG_W-1:11];
      sv  = a[ANG_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
      le  = {{(ANG_W-9-OUT_W){lim[OUT_W-1]}}, lim};
      if (sv > le) begin
         sv = le;
      end else if (sv < -le) begin
         sv = -le;
      end
      return sv[OUT_W-1:0];
   endfunction

endpackage

/* hw/rtl/qte_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// one digit of the restoring integer square root, carries the transaction
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [qte_pkg::SQ_W-1:0] step,
   input  qte_pkg::sq_type   prev_sq,
   output qte_pkg::sq_type   sq_ff
);
   import qte_pkg::*;

   sq_type           sq_in;
   logic [5:0]       sh;
   logic [RAD_W-1:0] bit_v;
   logic [RAD_W-1:0] trial;

   always_comb begin
      sh    = 6'd56 - {step, 1'b0};
      bit_v = RAD_W'(1) << sh;
      trial = prev_sq.res + bit_v;
      sq_in = prev_sq;
      sq_in.valid = prev_sq.valid && !reset;
      if ({1'b0, prev_sq.rem} >= trial) begin
         sq_in.rem = prev_sq.rem - trial[REM_W-1:0];
         sq_in.res = (prev_sq.res >> 1) + bit_v;
      end else begin
         sq_in.res = prev_sq.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en || reset) begin
         sq_ff <= sq_in;
      end
   end

endmodule

/* hw/rtl/qte_cordic_cell.sv */
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring rotation for the roll, pitch and yaw lanes
// ----------------------------------------------------------------------------
module qte_cordic_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [qte_pkg::STEP_W-1:0] step,
   input  qte_pkg::cd_type   prev_cd,
   output qte_pkg::cd_type   cd_ff
);
   import qte_pkg::*;

   cd_type cd_in;

   function automatic lane_type rotate(input lane_type l, input logic [STEP_W-1:0] i);
      lane_type                r;
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      logic signed [ANG_W-1:0] da;
      dx = l.y >>> i;
      dy = l.x >>> i;
      da = $signed(atan_entry(i));
      r  = l;
      if (!l.y[VEC_W-1]) begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + da;
      end else begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - da;
      end
      return r;
   endfunction

   always_comb begin
      cd_in       = prev_cd;
      cd_in.valid = prev_cd.valid && !reset;
      cd_in.roll  = rotate(prev_cd.roll, step);
      cd_in.pitch = rotate(prev_cd.pitch, step);
      cd_in.yaw   = rotate(prev_cd.yaw, step);
   end

   always_ff @(posedge clock) begin
      if (en || reset) begin
         cd_ff <= cd_in;
      end
   end

endmodule

/* hw/rtl/quaternion_to_euler_angles.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// the pipeline runs through the 29 square root cells and the CORDIC cells;
// throughput: one transaction per cycle, but the whole pipeline holds
// while a result waits under rsp_stall
// reset clears all valid bits, results appear only for accepted inputs
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_clamped
);
   import qte_pkg::*;

   logic adv;

   logic                     v1_ff;
   logic signed [PROD_W-1:0] wx_ff, yz_ff, wy_ff, zx_ff, wz_ff, xy_ff, xx_ff, yy_ff, zz_ff;

   sq_type s2_in, s2_ff;
   sq_type s3_in, s3_ff;
   sq_type sq_head;
   sq_type sq_chain [0:SQRT_STEPS];

   cd_type cd_entry_in, cd_entry_ff;
   cd_type cd_chain [0:CORDIC_STEPS];
   cd_type fin;

   logic signed [28:0]       sp_n;
   logic signed [RAD_W-1:0]  sp_sq;
   logic signed [TERM_W-1:0] c_term;

   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  roll_in, yaw_in, pitch_full;
   logic signed [OUT_W-1:0]  rsp_roll_ff, rsp_yaw_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic                     rsp_clamp_ff;

   function automatic logic signed [TERM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
      return {{(TERM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // products
   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   // product terms
   always_comb begin
      s2_in       = '0;
      s2_in.valid = v1_ff && !reset;
      s2_in.sr    = (ext(wx_ff) + ext(yz_ff)) <<< 1;
      s2_in.cr    = ONE_Q28 - ((ext(xx_ff) + ext(yy_ff)) <<< 1);
      s2_in.sp    = (ext(wy_ff) - ext(zx_ff)) <<< 1;
      s2_in.sy    = (ext(wz_ff) + ext(xy_ff)) <<< 1;
      s2_in.cy    = ONE_Q28 - ((ext(yy_ff) + ext(zz_ff)) <<< 1);
      s2_in.clamp = (s2_in.sp >= ONE_Q28) || (s2_in.sp <= -ONE_Q28);
      s2_in.sp_pos = (s2_in.sp > 0);
   end

   // square of the pitch sine, parked in rem
   always_comb begin
      sp_n        = s2_ff.sp[28:0];
      sp_sq       = sp_n * sp_n;
      s3_in       = s2_ff;
      s3_in.valid = s2_ff.valid && !reset;
      s3_in.rem   = sp_sq[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv || reset) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   always_comb begin
      sq_head     = s3_ff;
      sq_head.res = '0;
      sq_head.rem = s3_ff.clamp ? '0 : ((REM_W'(1) << 56) - s3_ff.rem);
   end

   assign sq_chain[0] = sq_head;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .step    (SQ_W'(g)),
         .prev_sq (sq_chain[g]),
         .sq_ff   (sq_chain[g+1])
      );
   end

   always_comb begin
      c_term             = {{(TERM_W-29){1'b0}}, sq_chain[SQRT_STEPS].res[28:0]};
      cd_entry_in.valid  = sq_chain[SQRT_STEPS].valid && !reset;
      cd_entry_in.clamp  = sq_chain[SQRT_STEPS].clamp;
      cd_entry_in.sp_pos = sq_chain[SQRT_STEPS].sp_pos;
      cd_entry_in.roll   = prerot(sq_chain[SQRT_STEPS].sr, sq_chain[SQRT_STEPS].cr);
      cd_entry_in.pitch  = prerot(sq_chain[SQRT_STEPS].sp, c_term);
      cd_entry_in.yaw    = prerot(sq_chain[SQRT_STEPS].sy, sq_chain[SQRT_STEPS].cy);
   end

   always_ff @(posedge clock) begin
      if (adv || reset) begin
         cd_entry_ff <= cd_entry_in;
      end
   end

   assign cd_chain[0] = cd_entry_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      qte_cordic_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .step    (STEP_W'(g)),
         .prev_cd (cd_chain[g]),
         .cd_ff   (cd_chain[g+1])
      );
   end

   assign fin = cd_chain[CORDIC_STEPS];

   always_comb begin
      roll_in = fin.roll.zero ? '0 : round_angle(fin.roll.z, PI_Q13);
      yaw_in  = fin.yaw.zero ? '0 : round_angle(fin.yaw.z, PI_Q13);
      if (fin.clamp) begin
         pitch_full = fin.sp_pos ? HALF_PI_Q13 : -HALF_PI_Q13;
      end else if (fin.pitch.zero) begin
         pitch_full = '0;
      end else begin
         pitch_full = round_angle(fin.pitch.z, HALF_PI_Q13);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_roll_ff  <= roll_in;
         rsp_yaw_ff   <= yaw_in;
         rsp_pitch_ff <= pitch_full[PITCH_W-1:0];
         rsp_clamp_ff <= fin.clamp;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.valid;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = rsp_roll_ff;
   assign rsp_pitch_angle   = rsp_pitch_ff;
   assign rsp_yaw_angle     = rsp_yaw_ff;
   assign rsp_pitch_clamped = rsp_clamp_ff;

   a_clamp_pitch : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_clamped |->
         (rsp_pitch_angle == 15'sd12868) || (rsp_pitch_angle == -15'sd12868))
      else $error("clamped pitch is not a right angle");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd25736) && (rsp_roll_angle >= -16'sd25736) &&
         (rsp_yaw_angle <= 16'sd25736) && (rsp_yaw_angle >= -16'sd25736) &&
         (rsp_pitch_angle <= 15'sd12868) && (rsp_pitch_angle >= -15'sd12868))
      else $error("angle out of range");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
